// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define FSA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication from one cycle to the next, outside reset
`define FSA_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/fsa_pkg.sv =====
`default_nettype none

package fsa_pkg;

  localparam int MAX_SLOTS_DEFAULT = 256;

  // fixed field widths of the channels and the register
  localparam int OP_W     = 1;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] ADDR_POOL_SLOTS = 3'd0;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NONE_USED = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/fsa_req_if.sv =====
`default_nettype none

interface fsa_req_if
  import fsa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   slot_index;

  modport source (output valid, output operation, output slot_index, input ready);
  modport sink   (input valid, input operation, input slot_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/fsa_rsp_if.sv =====
`default_nettype none

interface fsa_rsp_if
  import fsa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    granted_slot;
  logic [COUNT_W-1:0]  held_count;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, output status, output granted_slot, output held_count,
                  output free_count, input ready);
  modport sink   (input valid, input status, input granted_slot, input held_count,
                  input free_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/free_list_slot_allocator_top.sv =====
// channel  | dir | payload                                         | handshake
// req      | in  | operation, slot_index                           | valid/ready
// rsp      | out | status, granted_slot, held_count, free_count    | valid/ready
// apb      | in  | pool_slots at byte address 0                    | psel/penable
//
// every request goes through accept and link table read, then update
// the link table is a one-port synchronous ram; a pop needs its read data
// before the new list head is known, so one request is in flight at a time
// rst resets head, counters and valid flags; no clearing pass
// a request is taken while the previous word still waits on rsp; the update
// cycle holds until the rsp register is free
`default_nettype none

`include "assert_macros.svh"

module free_list_slot_allocator_top
  import fsa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEFAULT
) (
  input  wire                 clk,
  input  wire                 rst,
  fsa_req_if.sink             req,
  fsa_rsp_if.source           rsp,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int CW = $clog2(MAX_SLOTS + 1);             // counts and links incl. null
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;     // compare width
  localparam logic [CW-1:0] NULL_LINK = CW'(MAX_SLOTS);

  state_t state, state_next;

  logic [CW-1:0]    pool_slots;
  logic [CW-1:0]    head, head_next;
  logic [CW-1:0]    untouched, untouched_next;
  logic [CW-1:0]    allocated, allocated_next;
  logic             op_q;
  logic [IDX_W-1:0] idx_q;

  logic [CW-1:0]    link_mem [MAX_SLOTS];
  logic [CW-1:0]    rd_data;

  logic             rsp_valid;
  status_t          status_q, status_next;
  logic [IDX_W-1:0] granted_q, granted_next;
  logic [COUNT_W-1:0] used_q, free_q;

  logic             accept, exec_go, cfg_wr, mem_wr;
  logic [WW-1:0]    cfg_raw;
  logic [CW-1:0]    cfg_val;

  assign accept  = req.valid && req.ready;
  assign exec_go = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  assign cfg_wr  = psel && penable && pwrite && pready && (paddr == ADDR_POOL_SLOTS);

  assign pready = 1'b1;
  assign prdata = PDATA_W'(pool_slots);

  // out-of-range writes clamp into 1..MAX_SLOTS; pwdata bits above COUNT_W-1 are ignored
  always_comb begin
    cfg_raw = WW'(pwdata[COUNT_W-1:0]);
    if (cfg_raw == '0) begin
      cfg_val = CW'(1);
    end else if (cfg_raw > WW'(MAX_SLOTS)) begin
      cfg_val = NULL_LINK;
    end else begin
      cfg_val = CW'(cfg_raw);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept)  state_next = S_EXEC;
      S_EXEC:  if (exec_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the state machine and the pool update
  always_comb begin
    req.ready      = (state == S_IDLE);
    head_next      = head;
    untouched_next = untouched;
    allocated_next = allocated;
    status_next    = ST_OK;
    granted_next   = '0;
    mem_wr         = 1'b0;
    if (op_q == OP_ALLOC) begin
      if (allocated >= pool_slots) begin
        status_next = ST_EMPTY;
      end else if (head < NULL_LINK) begin
        granted_next   = IDX_W'(head);
        head_next      = (rd_data > NULL_LINK) ? NULL_LINK : rd_data;
        allocated_next = allocated + CW'(1);
      end else if (untouched != '0) begin
        untouched_next = untouched - CW'(1);
        granted_next   = IDX_W'(untouched - CW'(1));
        allocated_next = allocated + CW'(1);
      end else begin
        status_next = ST_EMPTY;
      end
    end else begin
      if (WW'(idx_q) >= WW'(pool_slots)) begin
        status_next = ST_RANGE;
      end else if (allocated == '0) begin
        status_next = ST_NONE_USED;
      end else begin
        mem_wr         = exec_go;
        head_next      = CW'(idx_q);
        allocated_next = allocated - CW'(1);
      end
    end
  end

  // link table: one port, read on accept, write on a push
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      link_mem[IW'(idx_q)] <= head;
    end else if (accept && (head < NULL_LINK)) begin
      rd_data <= link_mem[IW'(head)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.operation;
      idx_q <= req.slot_index;
    end
    if (exec_go) begin
      status_q  <= status_next;
      granted_q <= granted_next;
      used_q    <= COUNT_W'(allocated_next);
      free_q    <= COUNT_W'(pool_slots - allocated_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      pool_slots <= NULL_LINK;
      head       <= NULL_LINK;
      untouched  <= NULL_LINK;
      allocated  <= '0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_wr) begin
        pool_slots <= cfg_val;
        head       <= NULL_LINK;
        untouched  <= cfg_val;
        allocated  <= '0;
      end else if (exec_go) begin
        head      <= head_next;
        untouched <= untouched_next;
        allocated <= allocated_next;
      end
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = status_q;
  assign rsp.granted_slot = granted_q;
  assign rsp.held_count   = used_q;
  assign rsp.free_count   = free_q;

  `FSA_ASSERT(a_used_in_pool, allocated <= pool_slots, "allocated count above pool size")
  `FSA_ASSERT(a_untouched_in_pool, untouched <= pool_slots, "untouched count above pool size")
  `FSA_ASSERT(a_head_range, head <= NULL_LINK, "free list head beyond null marker")
  `FSA_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted word did not start update")
  `FSA_ASSERT_NEXT(a_exec_rsp, exec_go, rsp_valid, "update did not present a response")

endmodule

`default_nettype wire
